FILE: rtl/core/whb_pkg.sv
`default_nettype none

package whb_pkg;

    // Sizes of the histogram.
    localparam int MAX_BINS   = 64;
    localparam int VALUE_BITS = 32;
    localparam int TOTAL_BITS = 40;
    localparam int WEIGHT_W   = 16;
    localparam int SLOT_W     = 7;
    localparam int BIN_W      = $clog2(MAX_BINS);
    // Wide enough for an edge count of MAX_BINS + 1.
    localparam int CNT_W      = $clog2(MAX_BINS + 2);
    localparam int CFG_IDX_W  = 2;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_EDGE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_LOW  = 2'd0,
        CFG_RANGE_HIGH = 2'd1,
        CFG_BINS       = 2'd2,
        CFG_SPARE      = 2'd3
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_UPDATE,
        ST_READ
    } t_state;

    // Token that walks down the chain and counts edges at or below the sample.
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
    } t_token;

    // One bin as it shifts toward the output during a readout.
    typedef struct packed {
        logic [TOTAL_BITS-1:0]        total;
        logic signed [VALUE_BITS-1:0] lower_edge;
    } t_bin_rec;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                         edge_we;
        logic [SLOT_W-1:0]            edge_slot;
        logic signed [VALUE_BITS-1:0] edge_value;
        logic signed [VALUE_BITS-1:0] sample_value;
        logic [WEIGHT_W-1:0]          weight;
        logic [CNT_W-1:0]             nb_used;
        logic                         clear;
        logic                         upd_en;
        logic [BIN_W-1:0]             upd_idx;
        logic                         load;
        logic                         shift;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: rtl/core/whb_cell.sv
`default_nettype none

module whb_cell
    import whb_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire  [BIN_W-1:0] i_index,
    input  wire t_cell_ctrl  i_ctrl,
    input  wire t_token      i_token,
    output t_token           o_token,
    input  wire t_bin_rec    i_shift_in,
    output t_bin_rec         o_shift_out
);

    logic signed [VALUE_BITS-1:0] r_edge;
    logic [TOTAL_BITS-1:0]        r_total;
    t_token                       r_token;
    t_token                       n_token;
    t_bin_rec                     r_shift;
    logic                         edge_hit;
    logic [TOTAL_BITS:0]          sum;

    // This edge counts when it is in use and lies at or below the sample.
    assign edge_hit = ({1'b0, i_index} <= i_ctrl.nb_used) &&
                      (r_edge <= i_ctrl.sample_value);

    always_comb begin
        n_token.valid = i_token.valid;
        n_token.count = i_token.count + CNT_W'(edge_hit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token <= '0;
        end else begin
            r_token <= n_token;
        end
    end

    // Lower edge of this bin, written by an edge request for this slot.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.edge_we && (i_ctrl.edge_slot == SLOT_W'(i_index))) begin
            r_edge <= i_ctrl.edge_value;
        end
    end

    // Saturating accumulation of the bin total.
    assign sum = {1'b0, r_total} + (TOTAL_BITS + 1)'(i_ctrl.weight);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_ctrl.clear) begin
            r_total <= '0;
        end else if (i_ctrl.upd_en && (i_ctrl.upd_idx == i_index)) begin
            r_total <= sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];
        end
    end

    // Readout shift stage: snapshot the bin, then pass toward bin zero.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_shift.total      <= r_total;
            r_shift.lower_edge <= r_edge;
        end else if (i_ctrl.shift) begin
            r_shift <= i_shift_in;
        end
    end

    assign o_token     = r_token;
    assign o_shift_out = r_shift;

endmodule

`default_nettype wire

FILE: rtl/core/weighted_histogram_binner.sv
// Add sample: an accepted request passes the launch register, each cell of the
// 64-cell chain, the bin choice register and the update state before the next one.
// Write edge and clear counts act as the request is accepted. Readout: one bin per
// cycle from the shift chain while the output is not stalled, one for each bin in use.
// Synchronous active-low reset clears all bin totals and restores the default
// configuration; edges hold no reset value and must be written before use.
`default_nettype none

module weighted_histogram_binner
    import whb_pkg::*;
(
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Configuration write channel
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire  [VALUE_BITS-1:0]        i_cfg_data,
    // Request channel
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [1:0]                   i_operation,
    input  wire  signed [VALUE_BITS-1:0] i_sample_value,
    input  wire  [WEIGHT_W-1:0]          i_sample_weight,
    input  wire  [SLOT_W-1:0]            i_edge_slot,
    // Result channel
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [BIN_W-1:0]             o_bin_number,
    output logic [TOTAL_BITS-1:0]        o_bin_total,
    output logic signed [VALUE_BITS-1:0] o_bin_lower_edge,
    output logic                         o_final_bin
);

    t_state                       r_state;
    t_state                       n_state;
    logic signed [VALUE_BITS-1:0] r_range_low;
    logic signed [VALUE_BITS-1:0] r_range_high;
    logic [SLOT_W-1:0]            r_bins;
    logic [CNT_W-1:0]             nb_used;
    logic signed [VALUE_BITS-1:0] r_edge_last;
    logic signed [VALUE_BITS-1:0] r_val;
    logic [WEIGHT_W-1:0]          r_wt;
    logic                         r_in_range;
    logic                         r_at_high;
    logic                         r_launch;
    logic                         r_upd_en;
    logic [BIN_W-1:0]             r_upd_idx;
    logic                         n_upd_en;
    logic [CNT_W-1:0]             n_upd_idx;
    logic [CNT_W-1:0]             final_cnt;
    logic [CNT_W-1:0]             idx_m1;
    logic                         last_hit;
    logic [CNT_W-1:0]             r_rd_cnt;
    logic                         rd_last;
    logic                         in_acc;
    logic                         shift;
    logic                         upd_pulse;
    logic                         r_out_valid;
    logic [BIN_W-1:0]             r_out_bin;
    logic [TOTAL_BITS-1:0]        r_out_total;
    logic signed [VALUE_BITS-1:0] r_out_edge;
    logic                         r_out_final;
    t_cell_ctrl                   ctrl;
    t_token                       tok   [MAX_BINS+1];
    t_bin_rec                     sh    [MAX_BINS+1];

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign in_acc      = i_valid && o_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= {1'b1, {(VALUE_BITS-1){1'b0}}};
            r_range_high <= {1'b0, {(VALUE_BITS-1){1'b1}}};
            r_bins       <= SLOT_W'(MAX_BINS);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RANGE_LOW:  r_range_low  <= i_cfg_data;
                CFG_RANGE_HIGH: r_range_high <= i_cfg_data;
                CFG_BINS:       r_bins       <= i_cfg_data[SLOT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Bins in use, clamped to one through MAX_BINS.
    always_comb begin
        if (r_bins == '0) begin
            nb_used = CNT_W'(1);
        end else if (r_bins > SLOT_W'(MAX_BINS)) begin
            nb_used = CNT_W'(MAX_BINS);
        end else begin
            nb_used = CNT_W'(r_bins);
        end
    end

    // The edge past the last cell is kept here.
    always_ff @(posedge i_clk) begin
        if (in_acc && (t_op'(i_operation) == OP_EDGE) &&
            (i_edge_slot == SLOT_W'(MAX_BINS))) begin
            r_edge_last <= i_sample_value;
        end
    end

    // Sample capture and range test at acceptance.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_val      <= i_sample_value;
            r_wt       <= i_sample_weight;
            r_in_range <= (i_sample_value >= r_range_low) &&
                          (i_sample_value <= r_range_high);
            r_at_high  <= (i_sample_value == r_range_high);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch <= 1'b0;
        end else begin
            r_launch <= in_acc && (t_op'(i_operation) == OP_ADD);
        end
    end

    // Bin choice once the token leaves the chain.
    assign last_hit  = (nb_used == CNT_W'(MAX_BINS)) && (r_edge_last <= r_val);
    assign final_cnt = tok[MAX_BINS].count + CNT_W'(last_hit);
    assign idx_m1    = final_cnt - CNT_W'(1);

    always_comb begin
        n_upd_en  = 1'b1;
        n_upd_idx = idx_m1;
        if (!r_in_range || (final_cnt == '0)) begin
            n_upd_en = 1'b0;
        end else if (idx_m1 >= nb_used) begin
            // At or past the last edge only the range maximum is kept.
            n_upd_en  = r_at_high;
            n_upd_idx = nb_used - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd_en <= 1'b0;
        end else if (tok[MAX_BINS].valid) begin
            r_upd_en <= n_upd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tok[MAX_BINS].valid) begin
            r_upd_idx <= n_upd_idx[BIN_W-1:0];
        end
    end

    assign rd_last = (r_rd_cnt == (nb_used - CNT_W'(1)));

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and cell control.
    always_comb begin
        n_state         = r_state;
        ctrl            = '0;
        ctrl.edge_slot  = i_edge_slot;
        ctrl.edge_value = i_sample_value;
        ctrl.sample_value = r_val;
        ctrl.weight     = r_wt;
        ctrl.nb_used    = nb_used;
        ctrl.upd_idx    = r_upd_idx;
        shift           = 1'b0;
        upd_pulse       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (t_op'(i_operation))
                        OP_ADD:   n_state = ST_COUNT;
                        OP_EDGE:  ctrl.edge_we = 1'b1;
                        OP_CLEAR: ctrl.clear = 1'b1;
                        OP_READ: begin
                            ctrl.load = 1'b1;
                            n_state   = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_COUNT: begin
                if (tok[MAX_BINS].valid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                upd_pulse   = 1'b1;
                ctrl.upd_en = r_upd_en;
                n_state     = ST_IDLE;
            end
            ST_READ: begin
                shift      = !r_out_valid || i_ready;
                ctrl.shift = shift;
                if (shift && rd_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Chain of bin cells.
    assign tok[0].valid   = r_launch;
    assign tok[0].count   = '0;
    assign sh[MAX_BINS]   = '0;

    for (genvar g = 0; g < MAX_BINS; g++) begin : g_cell
        whb_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_index     (BIN_W'(g)),
            .i_ctrl      (ctrl),
            .i_token     (tok[g]),
            .o_token     (tok[g+1]),
            .i_shift_in  (sh[g+1]),
            .o_shift_out (sh[g])
        );
    end

    // Readout counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt <= '0;
        end else if (ctrl.load) begin
            r_rd_cnt <= '0;
        end else if (shift) begin
            r_rd_cnt <= r_rd_cnt + CNT_W'(1);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (shift) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_out_bin   <= r_rd_cnt[BIN_W-1:0];
            r_out_total <= sh[0].total;
            r_out_edge  <= sh[0].lower_edge;
            r_out_final <= rd_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_bin_number     = r_out_bin;
    assign o_bin_total      = r_out_total;
    assign o_bin_lower_edge = r_out_edge;
    assign o_final_bin      = r_out_final;

    // The counting token only leaves the chain while an add is in progress.
    a_token_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[MAX_BINS].valid |-> (r_state == ST_COUNT))
        else $error("count token left the chain outside an add");

    // A readout never presents a bin beyond those in use.
    a_bin_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ({1'b0, r_out_bin} < nb_used))
        else $error("readout bin number beyond bins in use");

    // The final bin ends the readout.
    a_read_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && shift && rd_last) |=> (r_state == ST_IDLE))
        else $error("readout did not end after the final bin");

    // A bin update is a one-cycle pulse after the token leaves the chain.
    a_update_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_pulse |=> !upd_pulse)
        else $error("bin update repeated");

endmodule

`default_nettype wire
